/* rtl/srht_pkg.sv */
// Shared constants and types for the search result hash table.
`timescale 1ns / 1ps

package srht_pkg;

    // Slot count; must be a power of two, the slot is the low key bits.
    localparam int TABLE_ENTRIES = 16384;
    localparam int INDEX_W       = $clog2(TABLE_ENTRIES);

    localparam int KEY_W   = 64;
    localparam int SCORE_W = 32;
    localparam int MOVE_W  = 32;
    localparam int DEPTH_W = 8;
    localparam int KIND_W  = 2;
    localparam int AGE_W   = 8;

    typedef enum logic [1:0] {
        CMD_PROBE  = 2'd0,
        CMD_RECORD = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UPPER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOWER = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load_in;   // capture transaction, start slot read
        logic eval;      // resolve slot, update it, load result register
        logic sweep;     // zero one slot of the clear sweep
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_clear;
        logic sweep_last;
    } dp_stat_t;

endpackage

/* rtl/srht_ctrl.sv */
// Control state machine: accept, evaluate and clear sweep sequencing.
`timescale 1ns / 1ps

module srht_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output srht_pkg::dp_cmd_t dp_cmd,
    input  srht_pkg::dp_stat_t dp_stat
);
    import srht_pkg::*;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EVAL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        dp_cmd         = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_SWEEP:
            begin
                dp_cmd.sweep = 1'b1;
                if (dp_stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dp_cmd.load_in = 1'b1;
                    state_next     = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    dp_cmd.eval    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = dp_stat.is_clear ? ST_SWEEP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/srht_dp.sv */
// Datapath: slot memory, transaction registers, probe/record logic, result register.
`timescale 1ns / 1ps

module srht_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  srht_pkg::dp_cmd_t                    dp_cmd,
    output srht_pkg::dp_stat_t                   dp_stat,
    input  logic                                 cfg_valid,
    input  logic [srht_pkg::AGE_W-1:0]           cfg_data,
    input  logic [1:0]                           command,
    input  logic [srht_pkg::KEY_W-1:0]           position_key,
    input  logic [srht_pkg::DEPTH_W-1:0]         search_depth,
    input  logic signed [srht_pkg::SCORE_W-1:0]  window_low,
    input  logic signed [srht_pkg::SCORE_W-1:0]  window_high,
    input  logic signed [srht_pkg::SCORE_W-1:0]  new_value,
    input  logic [srht_pkg::KIND_W-1:0]          bound_kind,
    input  logic [srht_pkg::MOVE_W-1:0]          move_in,
    output logic                                 key_hit,
    output logic                                 score_valid,
    output logic signed [srht_pkg::SCORE_W-1:0]  score_out,
    output logic                                 move_valid,
    output logic [srht_pkg::MOVE_W-1:0]          best_move_out,
    output logic [srht_pkg::DEPTH_W-1:0]         entry_depth,
    output logic [srht_pkg::KIND_W-1:0]          entry_kind,
    output logic signed [srht_pkg::SCORE_W-1:0]  entry_value,
    output logic [srht_pkg::AGE_W-1:0]           entry_age,
    output logic                                 written
);
    import srht_pkg::*;

    typedef struct packed {
        logic [KEY_W-1:0]   tag;
        logic [MOVE_W-1:0]  move;
        logic [SCORE_W-1:0] value;
        logic [DEPTH_W-1:0] depth;
        logic [KIND_W-1:0]  kind;
        logic [AGE_W-1:0]   age;
    } slot_t;

    slot_t mem [TABLE_ENTRIES];
    slot_t rd_reg;

    // captured transaction
    cmd_t                cmd_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [DEPTH_W-1:0]  depth_reg;
    logic [SCORE_W-1:0]  alpha_reg;
    logic [SCORE_W-1:0]  beta_reg;
    logic [SCORE_W-1:0]  val_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [MOVE_W-1:0]   move_reg;

    logic [AGE_W-1:0]    age_reg;
    logic [INDEX_W-1:0]  sweep_idx_reg;
    logic [INDEX_W-1:0]  sweep_idx_next;

    // result register
    logic                hit_reg;
    logic                sv_reg;
    logic [SCORE_W-1:0]  score_reg;
    logic                mv_reg;
    logic [MOVE_W-1:0]   bmove_reg;
    logic [DEPTH_W-1:0]  edepth_reg;
    logic [KIND_W-1:0]   ekind_reg;
    logic [SCORE_W-1:0]  evalue_reg;
    logic [AGE_W-1:0]    eage_reg;
    logic                wr_reg;

    // evaluation
    logic                hit;
    logic                got;
    logic [SCORE_W-1:0]  sc;
    logic                replace;
    logic                r_sv;
    logic [SCORE_W-1:0]  r_score;
    logic                r_mv;
    logic [MOVE_W-1:0]   r_move;
    logic                r_ent;
    logic                r_wr;
    logic                we;
    logic [INDEX_W-1:0]  wr_addr;
    slot_t               wr_data;
    logic                sweep_last;

    assign sweep_last = (sweep_idx_reg == INDEX_W'(TABLE_ENTRIES - 1));
    assign sweep_idx_next = sweep_last ? '0 : sweep_idx_reg + INDEX_W'(1);

    assign dp_stat.is_clear   = (cmd_reg == CMD_CLEAR);
    assign dp_stat.sweep_last = sweep_last;

    always_comb
    begin
        hit     = (cmd_reg != CMD_CLEAR) && (rd_reg.tag == key_reg);
        replace = (age_reg > rd_reg.age) || (rd_reg.depth <= depth_reg);
        got     = 1'b0;
        sc      = '0;
        if (rd_reg.depth >= depth_reg)
        begin
            case (rd_reg.kind)
                KIND_EXACT:
                begin
                    got = 1'b1;
                    sc  = rd_reg.value;
                end
                KIND_UPPER:
                begin
                    if ($signed(rd_reg.value) <= $signed(alpha_reg))
                    begin
                        got = 1'b1;
                        sc  = alpha_reg;
                    end
                end
                KIND_LOWER:
                begin
                    if ($signed(rd_reg.value) >= $signed(beta_reg))
                    begin
                        got = 1'b1;
                        sc  = beta_reg;
                    end
                end
                default:
                begin
                    got = 1'b0;
                end
            endcase
        end

        r_sv    = 1'b0;
        r_score = '0;
        r_mv    = 1'b0;
        r_move  = '0;
        r_ent   = 1'b0;
        r_wr    = 1'b0;
        case (cmd_reg)
            CMD_PROBE:
            begin
                if (hit && got)
                begin
                    r_sv    = 1'b1;
                    r_score = sc;
                end
                else if (hit)
                begin
                    r_mv   = 1'b1;
                    r_move = rd_reg.move;
                end
            end
            CMD_RECORD:
            begin
                r_wr = replace;
            end
            CMD_LOOKUP:
            begin
                if (hit)
                begin
                    r_mv   = 1'b1;
                    r_move = rd_reg.move;
                    r_ent  = 1'b1;
                end
            end
            default:
            begin
                r_wr = 1'b0;
            end
        endcase

        we      = dp_cmd.sweep || (dp_cmd.eval && r_wr);
        wr_addr = dp_cmd.sweep ? sweep_idx_reg : key_reg[INDEX_W-1:0];
        wr_data = '0;
        if (!dp_cmd.sweep)
        begin
            wr_data.tag   = key_reg;
            wr_data.move  = move_reg;
            wr_data.value = val_reg;
            wr_data.depth = depth_reg;
            wr_data.kind  = kind_reg;
            wr_data.age   = age_reg;
        end
    end

    // slot memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (dp_cmd.load_in)
        begin
            rd_reg <= mem[position_key[INDEX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_in)
        begin
            cmd_reg   <= cmd_t'(command);
            key_reg   <= position_key;
            depth_reg <= search_depth;
            alpha_reg <= window_low;
            beta_reg  <= window_high;
            val_reg   <= new_value;
            kind_reg  <= bound_kind;
            move_reg  <= move_in;
        end
        if (dp_cmd.eval)
        begin
            hit_reg    <= hit;
            sv_reg     <= r_sv;
            score_reg  <= r_score;
            mv_reg     <= r_mv;
            bmove_reg  <= r_move;
            edepth_reg <= r_ent ? rd_reg.depth : '0;
            ekind_reg  <= r_ent ? rd_reg.kind  : '0;
            evalue_reg <= r_ent ? rd_reg.value : '0;
            eage_reg   <= r_ent ? rd_reg.age   : '0;
            wr_reg     <= r_wr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg       <= '0;
            sweep_idx_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                age_reg <= cfg_data;
            end
            if (dp_cmd.sweep)
            begin
                sweep_idx_reg <= sweep_idx_next;
            end
        end
    end

    assign key_hit       = hit_reg;
    assign score_valid   = sv_reg;
    assign score_out     = score_reg;
    assign move_valid    = mv_reg;
    assign best_move_out = bmove_reg;
    assign entry_depth   = edepth_reg;
    assign entry_kind    = ekind_reg;
    assign entry_value   = evalue_reg;
    assign entry_age     = eage_reg;
    assign written       = wr_reg;

endmodule

/* rtl/search_result_hash_table.sv */
// Top level of the search result hash table: controller plus datapath.
`timescale 1ns / 1ps
// Probe, record and lookup: the accept cycle reads the slot into a register; the evaluate
// state, once the output side is free, resolves it, writes back and loads the result
// register, and out_valid rises as that register is loaded.
// A new transaction is taken only after the previous one has been evaluated and written back.
// Clear: the result is posted first, then the sweep zeroes every slot, one slot per cycle.
// Reset: async, active low; then a sweep of all TABLE_ENTRIES slots runs before
// the first input transaction is taken. Configuration writes are taken at any time.

module search_result_hash_table (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel (current_age)
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [srht_pkg::AGE_W-1:0]           cfg_data,
    // input transaction
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           command,
    input  logic [srht_pkg::KEY_W-1:0]           position_key,
    input  logic [srht_pkg::DEPTH_W-1:0]         search_depth,
    input  logic signed [srht_pkg::SCORE_W-1:0]  window_low,
    input  logic signed [srht_pkg::SCORE_W-1:0]  window_high,
    input  logic signed [srht_pkg::SCORE_W-1:0]  new_value,
    input  logic [srht_pkg::KIND_W-1:0]          bound_kind,
    input  logic [srht_pkg::MOVE_W-1:0]          move_in,
    // result transaction
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 key_hit,
    output logic                                 score_valid,
    output logic signed [srht_pkg::SCORE_W-1:0]  score_out,
    output logic                                 move_valid,
    output logic [srht_pkg::MOVE_W-1:0]          best_move_out,
    output logic [srht_pkg::DEPTH_W-1:0]         entry_depth,
    output logic [srht_pkg::KIND_W-1:0]          entry_kind,
    output logic signed [srht_pkg::SCORE_W-1:0]  entry_value,
    output logic [srht_pkg::AGE_W-1:0]           entry_age,
    output logic                                 written
);
    import srht_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // The age register is a plain register, always writable.
    assign cfg_ready = 1'b1;

    // Sequencer: sweep after reset, then accept -> evaluate -> accept.
    // A clear transaction posts its all-zero result first, then sweeps.
    srht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat)
    );

    // Slot memory, compare/select logic and the result register.
    // The result register decouples the output side: evaluation proceeds
    // as soon as the previous result is taken or being taken.
    srht_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .dp_stat       (dp_stat),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .command       (command),
        .position_key  (position_key),
        .search_depth  (search_depth),
        .window_low    (window_low),
        .window_high   (window_high),
        .new_value     (new_value),
        .bound_kind    (bound_kind),
        .move_in       (move_in),
        .key_hit       (key_hit),
        .score_valid   (score_valid),
        .score_out     (score_out),
        .move_valid    (move_valid),
        .best_move_out (best_move_out),
        .entry_depth   (entry_depth),
        .entry_kind    (entry_kind),
        .entry_value   (entry_value),
        .entry_age     (entry_age),
        .written       (written)
    );

endmodule
